>>> hdl/vfd_pkg.sv
// Package with the shared types and constants of the VADPCM frame decoder.
package vfd_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_DECODE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Command passed from the front part to the back part.
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_HEADER = 2'd2,
        CMD_DATA   = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [6:0]  coef_index;
        logic [15:0] coef_value;
        logic [7:0]  data_byte;
        logic        small_codec;
        logic [2:0]  first;
        logic        group_end;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_EMIT
    } t_state;

    localparam int unsigned ACC_W = 40;

endpackage

>>> hdl/vfd_front.sv
// Front part: accepts operations, tracks the frame position and classifies bytes.
module vfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_small_codec,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_operation,
    input  logic [6:0]    i_coef_index,
    input  logic [15:0]   i_coef_value,
    input  logic [7:0]    i_data_byte,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output vfd_pkg::t_cmd o_cmd
);
    import vfd_pkg::*;

    logic [3:0] r_pos, n_pos;
    logic [3:0] w_flen, w_idx;
    logic       w_hdr;
    t_cmd       w_cmd;
    logic       w_push;

    assign o_ready     = i_cmd_ready;
    assign w_push      = i_valid && i_cmd_ready;
    assign w_flen      = i_small_codec ? 4'd5 : 4'd9;
    assign w_hdr       = (r_pos == 4'd0) || (r_pos >= w_flen);
    assign w_idx       = r_pos - 4'd1;

    always_comb begin
        w_cmd             = '0;
        w_cmd.coef_index  = i_coef_index;
        w_cmd.coef_value  = i_coef_value;
        w_cmd.data_byte   = i_data_byte;
        w_cmd.small_codec = i_small_codec;
        n_pos             = r_pos;
        o_cmd_valid       = 1'b0;
        if (i_small_codec) begin
            w_cmd.first     = {w_idx[0], 2'b00};
            w_cmd.group_end = w_idx[0];
        end else begin
            w_cmd.first     = {w_idx[1:0], 1'b0};
            w_cmd.group_end = (w_idx[1:0] == 2'd3);
        end
        unique case (t_op'(i_operation))
            OP_LOAD: begin
                w_cmd.kind  = CMD_LOAD;
                o_cmd_valid = i_valid;
            end
            OP_START: begin
                w_cmd.kind  = CMD_START;
                o_cmd_valid = i_valid;
                n_pos       = 4'd0;
            end
            OP_DECODE: begin
                o_cmd_valid = i_valid;
                if (w_hdr) begin
                    w_cmd.kind = CMD_HEADER;
                    n_pos      = 4'd1;
                end else begin
                    w_cmd.kind = CMD_DATA;
                    n_pos      = (r_pos + 4'd1 >= w_flen) ? 4'd0 : r_pos + 4'd1;
                end
            end
            default: o_cmd_valid = 1'b0;
        endcase
    end

    assign o_cmd = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_push) begin
            r_pos <= n_pos;
        end
    end
endmodule

>>> hdl/vfd_queue.sv
// Two-entry queue between the front part and the back part.
module vfd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vfd_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output vfd_pkg::t_cmd o_cmd
);
    import vfd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> hdl/vfd_back.sv
// Back part: codebook memory, residual store and the shared multiply-accumulate.
module vfd_back #(
    parameter int unsigned PREDICTORS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  vfd_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [15:0]   o_sample,
    output logic          o_last
);
    import vfd_pkg::*;

    localparam int unsigned DEPTH = PREDICTORS * 16;

    // Codebook: one write port, one registered read port. A sweep clears it after reset.
    logic [15:0] r_cb [DEPTH];
    logic [6:0]  r_clr;
    logic        r_clearing;
    logic [6:0]  w_raddr;
    logic [15:0] r_coef;

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic signed [15:0] r_res [8];
    logic signed [15:0] r_hn, r_ho;
    logic [3:0]  r_shift;
    logic [2:0]  r_pred;
    logic [2:0]  r_sub;      // sample within this byte
    logic [3:0]  r_term;     // MAC term index
    logic        r_mac_v;    // coefficient of the previous term is valid
    logic [3:0]  r_mterm;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [15:0] r_out;
    logic        r_last, r_ovalid;
    logic signed [15:0] r_s_prev;

    logic [2:0]  w_j, w_cnt;
    logic [3:0]  w_nterms;
    logic signed [15:0] w_opnd;
    logic signed [31:0] w_prod;
    logic signed [ACC_W-1:0] w_sh;
    logic signed [15:0] w_clamp;

    assign w_cnt    = r_cmd.small_codec ? 3'd4 : 3'd2;
    assign w_j      = r_cmd.first + r_sub;
    // Terms: older history, newest history, then earlier residuals k = 0..j-1.
    assign w_nterms = 4'd2 + {1'b0, w_j};

    always_comb begin
        logic [3:0] k;
        k = r_term - 4'd2;
        if (r_term == 4'd0)      w_raddr = {r_pred, 1'b0, w_j};
        else if (r_term == 4'd1) w_raddr = {r_pred, 1'b1, w_j};
        else                     w_raddr = {r_pred, 1'b1, w_j - k[2:0] - 3'd1};
    end

    always_comb begin
        logic [3:0] k;
        k = r_mterm - 4'd2;
        if (r_mterm == 4'd0)      w_opnd = r_ho;
        else if (r_mterm == 4'd1) w_opnd = r_hn;
        else                      w_opnd = r_res[k[2:0]];
    end
    assign w_prod = $signed(r_coef) * w_opnd;

    assign w_sh = r_acc >>> 11;
    always_comb begin
        if (w_sh < -32768)     w_clamp = 16'sh8000;
        else if (w_sh > 32767) w_clamp = 16'sh7fff;
        else                   w_clamp = w_sh[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_cb[r_clr[$clog2(DEPTH)-1:0]] <= '0;
        end else if (r_state == ST_LOAD && {1'b0, r_cmd.coef_index} < 8'(DEPTH)) begin
            r_cb[r_cmd.coef_index[$clog2(DEPTH)-1:0]] <= r_cmd.coef_value;
        end
        r_coef <= r_cb[w_raddr[$clog2(DEPTH)-1:0]];
    end

    assign o_cmd_ready = (r_state == ST_IDLE) && !r_clearing;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !r_clearing) begin
                    if (i_cmd.kind == CMD_LOAD)      n_state = ST_LOAD;
                    else if (i_cmd.kind == CMD_DATA) n_state = ST_MAC;
                end
            end
            ST_LOAD: n_state = ST_IDLE;
            ST_MAC: begin
                if (!r_mac_v && r_term == w_nterms && r_mterm == w_nterms) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = (r_sub + 3'd1 == w_cnt) ? ST_IDLE : ST_MAC;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_ovalid   <= 1'b0;
            r_hn       <= '0;
            r_ho       <= '0;
            r_shift    <= '0;
            r_pred     <= '0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr <= r_clr + 7'd1;
                if (r_clr == 7'(DEPTH - 1)) r_clearing <= 1'b0;
            end
            if (r_state == ST_EMIT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && !r_clearing) begin
                        r_cmd <= i_cmd;
                        unique case (i_cmd.kind)
                            CMD_START: begin
                                r_hn <= '0;
                                r_ho <= '0;
                            end
                            CMD_HEADER: begin
                                r_shift <= i_cmd.data_byte[7:4];
                                r_pred  <= (i_cmd.data_byte[3:0] >= 4'(PREDICTORS))
                                           ? 3'(PREDICTORS - 1) : i_cmd.data_byte[2:0];
                            end
                            CMD_DATA: begin
                                for (int i = 0; i < 4; i++) begin
                                    logic signed [15:0] r;
                                    if (i_cmd.small_codec) begin
                                        if (i < 4) begin
                                            r = 16'($signed(i_cmd.data_byte[7-2*i -: 2]));
                                            r_res[i_cmd.first + 3'(i)] <= r <<< r_shift;
                                        end
                                    end else if (i < 2) begin
                                        r = 16'($signed(i_cmd.data_byte[7-4*i -: 4]));
                                        r_res[i_cmd.first + 3'(i)] <= r <<< r_shift;
                                    end
                                end
                                r_sub   <= '0;
                                r_term  <= '0;
                                r_mterm <= '0;
                                r_mac_v <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_LOAD: ;
                ST_MAC: begin
                    if (r_term == 4'd0 && !r_mac_v && r_mterm == 4'd0) begin
                        // Seed with the sample's own residual scaled by 2048.
                        r_acc <= ACC_W'(r_res[w_j]) <<< 11;
                    end
                    if (r_mac_v) begin
                        r_acc   <= ((r_term == 4'd1 && r_mterm == 4'd0) ? ACC_W'(r_res[w_j]) <<< 11
                                    : r_acc) + ACC_W'(w_prod);
                        r_mterm <= r_mterm + 4'd1;
                    end
                    if (r_term < w_nterms) begin
                        r_term  <= r_term + 4'd1;
                        r_mac_v <= 1'b1;
                    end else begin
                        r_mac_v <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out    <= w_clamp;
                        r_last   <= (r_sub + 3'd1 == w_cnt);
                        r_s_prev <= w_clamp;
                        if (r_sub + 3'd1 == w_cnt && r_cmd.group_end) begin
                            r_hn <= w_clamp;
                            r_ho <= r_s_prev;
                        end
                        r_sub   <= r_sub + 3'd1;
                        r_term  <= '0;
                        r_mterm <= '0;
                        r_mac_v <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_sample = r_out;
    assign o_last   = r_last;
endmodule

>>> hdl/vadpcm_frame_decoder_unit.sv
// Top level of the VADPCM frame decoder: front part, command queue and back part.
// Each sample j of a data byte is built from j + 2 products in the shared multiply-accumulate
// unit; the back part takes no new command until every sample of the byte has been emitted.
// A load passes through a load state; header and start commands are taken in the idle state.
// Reset is synchronous and active low; after reset a sweep clears all PREDICTORS*16 codebook
// entries, during which the back part takes no command from the queue.
module vadpcm_frame_decoder_unit #(
    parameter int unsigned PREDICTORS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // operation, coef_index, coef_value, data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pcm_sample
    output logic        m_axis_tlast    // last_of_run
);
    import vfd_pkg::*;

    logic r_small;
    t_cmd w_fcmd, w_bcmd;
    logic w_fvalid, w_fready, w_bvalid, w_bready;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small <= 1'b0;
        end else if (i_cfg_valid) begin
            r_small <= i_cfg_data;
        end
    end

    vfd_front u_front (
        .i_clk, .i_rst_n,
        .i_small_codec (r_small),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_operation   (s_axis_tdata[1:0]),
        .i_coef_index  (s_axis_tdata[8:2]),
        .i_coef_value  (s_axis_tdata[24:9]),
        .i_data_byte   (s_axis_tdata[32:25]),
        .o_cmd_valid   (w_fvalid),
        .i_cmd_ready   (w_fready),
        .o_cmd         (w_fcmd)
    );

    vfd_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid (w_fvalid), .o_ready (w_fready), .i_cmd (w_fcmd),
        .o_valid (w_bvalid), .i_ready (w_bready), .o_cmd (w_bcmd)
    );

    vfd_back #(.PREDICTORS(PREDICTORS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid (w_bvalid), .o_cmd_ready (w_bready), .i_cmd (w_bcmd),
        .o_valid (m_axis_tvalid), .i_ready (m_axis_tready),
        .o_sample (m_axis_tdata), .o_last (m_axis_tlast)
    );
endmodule

>>> hdl/vfd_checker.sv
// Port-level checker for the VADPCM frame decoder, bound to the top level.
module vfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        s_axis_tready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
        else $error("stalled last flag changed");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(s_axis_tready))
        else $error("input ready unknown");
endmodule

bind vadpcm_frame_decoder_unit vfd_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tlast, .s_axis_tready
);

>>> dv/tb.sv
// Self-checking testbench for the VADPCM frame decoder: directed table, then random frames.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vfd_pkg::*;

    localparam int PRED_COUNT = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } t_pcm;

    typedef struct {
        t_op         op;
        logic [6:0]  idx;
        logic [15:0] val;
        logic [7:0]  data;
        int          n_typed;
        logic [15:0] typed0;
        logic [15:0] typed1;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Decoder state kept by the testbench.
    int          coefs [128];
    int          hist_new;
    int          hist_old;
    int          frame_pos;
    int          shift_amt;
    int          pred_sel;
    int          residuals [8];
    bit          small_mode;

    t_pcm        pcm_expected [$];
    int          mismatches = 0;
    bit          hold_start = 1'b0;
    bit          holding = 1'b0;
    int          burst_left = 0;

    vadpcm_frame_decoder_unit #(.PREDICTORS(PRED_COUNT)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int sample_at(int j);
        int     base;
        longint acc;
        base = pred_sel * 16;
        acc = longint'(coefs[base + j]) * hist_old
            + longint'(coefs[base + 8 + j]) * hist_new
            + longint'(residuals[j]) * 2048;
        for (int k = 0; k < j; k++)
            acc += longint'(coefs[base + 8 + (j - k - 1)]) * residuals[k];
        acc = acc >>> 11;
        if (acc < -32768) return -32768;
        if (acc > 32767) return 32767;
        return int'(acc);
    endfunction

    // Advances the decoder state by one request and returns the samples it yields.
    function automatic void decode_request(t_op op, logic [6:0] idx, logic [15:0] val,
                                           logic [7:0] data, ref int samples [$]);
        int flen, per, cnt, first, gb, r;
        logic [15:0] w;
        samples = {};
        flen = small_mode ? 5 : 9;
        case (op)
            OP_LOAD: begin
                if (idx < PRED_COUNT * 16) coefs[idx] = $signed(val);
            end
            OP_START: begin
                hist_new = 0;
                hist_old = 0;
                frame_pos = 0;
            end
            OP_DECODE: begin
                if (frame_pos == 0 || frame_pos >= flen) begin
                    shift_amt = data[7:4];
                    pred_sel = (data[3:0] >= PRED_COUNT) ? PRED_COUNT - 1 : data[3:0];
                    frame_pos = 1;
                end else begin
                    per = small_mode ? 2 : 4;
                    cnt = small_mode ? 4 : 2;
                    gb = (frame_pos - 1) % per;
                    first = gb * cnt;
                    for (int i = 0; i < cnt; i++) begin
                        if (small_mode) r = $signed(data[7 - 2 * i -: 2]);
                        else r = $signed(data[7 - 4 * i -: 4]);
                        w = 16'(r << shift_amt);
                        residuals[first + i] = $signed(w);
                    end
                    for (int i = 0; i < cnt; i++) samples.push_back(sample_at(first + i));
                    if (gb == per - 1) begin
                        hist_old = samples[cnt - 2];
                        hist_new = samples[cnt - 1];
                    end
                    frame_pos++;
                    if (frame_pos >= flen) frame_pos = 0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Offers one request, with bursts and gaps on the sending side, until it is taken.
    task automatic push_request(t_op op, logic [6:0] idx, logic [15:0] val, logic [7:0] data,
                                int n_typed, logic [15:0] typed0, logic [15:0] typed1);
        int     got [$];
        logic [32:0] packed_req;
        t_pcm   e;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            wait_cycles($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        decode_request(op, idx, val, data, got);
        for (int i = 0; i < got.size(); i++) begin
            e.sample = (n_typed > 0) ? ((i == 0) ? typed0 : typed1) : got[i][15:0];
            e.last = (i == got.size() - 1);
            pcm_expected.push_back(e);
        end
        // The fields are packed from bit 0 upward and padded with zeros to five bytes.
        packed_req = {data, val, idx, logic'(op[1]), logic'(op[0])};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, packed_req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pcm_expected.size() != 0) @(posedge i_clk);
        wait_cycles(SETTLE_CYCLES);
    endtask

    task automatic write_codec(bit v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        small_mode = v;
    endtask

    task automatic random_phase(int n_items);
        t_op         op;
        logic [15:0] val;
        int          pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) op = OP_LOAD;
            else if (pick < 13) op = OP_START;
            else if (pick < 15) op = OP_NONE;
            else op = OP_DECODE;
            // Coefficients are mostly moderate so that samples do not all saturate.
            val = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 8192) - 4096);
            push_request(op, 7'($urandom), val, 8'($urandom), 0, '0, '0);
        end
    endtask

    // Rows with typed samples rely on the all-zero codebook after reset.
    t_row directed [] = '{
        '{OP_DECODE, 7'd0,   16'h0000, 8'h00, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h7F, 2, 16'd7,     16'hFFFF},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h80, 2, 16'hFFF8,  16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h12, 2, 16'd1,     16'd2},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h34, 2, 16'd3,     16'd4},
        '{OP_START,  7'd0,   16'h0000, 8'h00, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'hC8, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h88, 2, 16'h8000,  16'h8000},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h77, 2, 16'd28672, 16'd28672},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h11, 2, 16'd4096,  16'd4096},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h22, 2, 16'd8192,  16'd8192},
        '{OP_START,  7'd0,   16'h0000, 8'h00, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'hF0, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h13, 2, 16'h8000,  16'h8000},
        '{OP_NONE,   7'd5,   16'h1234, 8'h55, 0, 16'd0,     16'd0},
        '{OP_LOAD,   7'd127, 16'h7FFF, 8'h00, 0, 16'd0,     16'd0},
        '{OP_LOAD,   7'd0,   16'h8000, 8'h00, 0, 16'd0,     16'd0},
        '{OP_LOAD,   7'd8,   16'h7FFF, 8'h00, 0, 16'd0,     16'd0},
        '{OP_LOAD,   7'd9,   16'h04D2, 8'h00, 0, 16'd0,     16'd0},
        '{OP_START,  7'd0,   16'h0000, 8'h00, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h30, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h7F, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h80, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'hFF, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'h71, 0, 16'd0,     16'd0},
        '{OP_DECODE, 7'd0,   16'h0000, 8'hA5, 0, 16'd0,     16'd0}
    };

    initial begin
        for (int i = 0; i < 128; i++) coefs[i] = 0;
        for (int i = 0; i < 8; i++) residuals[i] = 0;
        hist_new = 0;
        hist_old = 0;
        frame_pos = 0;
        shift_amt = 0;
        pred_sel = 0;
        small_mode = 1'b0;
        wait_cycles(5);
        i_rst_n <= 1'b1;
        write_codec(1'b0);
        foreach (directed[i])
            push_request(directed[i].op, directed[i].idx, directed[i].val, directed[i].data,
                         directed[i].n_typed, directed[i].typed0, directed[i].typed1);
        drain_outputs();
        // The frame stands past the small codec's length here, so the next byte is a header.
        write_codec(1'b1);
        hold_start = 1'b1;
        random_phase(100);
        drain_outputs();
        write_codec(1'b0);
        random_phase(90);
        drain_outputs();
        write_codec(1'b1);
        random_phase(90);
        drain_outputs();
        write_codec(1'b0);
        random_phase(90);
        drain_outputs();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Long hold-off on the output so that the block backs up and stalls its input.
    initial begin
        wait (hold_start);
        wait_cycles(20);
        holding = 1'b1;
        wait_cycles(HOLD_CYCLES);
        holding = 1'b0;
    end

    always @(posedge i_clk) begin
        int mode_cycle;
        mode_cycle = int'(($time / 8) % 256);
        if (holding) begin
            m_axis_tready <= 1'b0;
        end else if (mode_cycle < 64) begin
            m_axis_tready <= 1'b1;
        end else if (mode_cycle < 160) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_pcm e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pcm_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %h last %b", m_axis_tdata, m_axis_tlast);
            end else begin
                e = pcm_expected.pop_front();
                if (m_axis_tdata !== e.sample || m_axis_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: expected %h last %b, got %h last %b",
                                 e.sample, e.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        #3ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
